// File: sv/gme_pkg.sv
// ----------------------------------------------------------------------------
// gme_pkg
// Shared types, constants and helpers for the Gram matrix engine.
// ----------------------------------------------------------------------------
package gme_pkg;

    // Default sizes, handed to the top level parameters
    localparam int MAX_ROWS_DEF   = 64;
    localparam int MAX_COLS_DEF   = 8;
    localparam int ELEM_WIDTH_DEF = 16;

    // Fixed field widths of the ports
    localparam int ROW_CNT_WIDTH   = 7;
    localparam int COL_CNT_WIDTH   = 4;
    localparam int IDX_WIDTH       = 3;
    localparam int DOT_WIDTH       = 38;
    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH  = 7;

    // Register values after reset
    localparam logic [ROW_CNT_WIDTH-1:0] ROW_COUNT_RST = 7'd64;
    localparam logic [COL_CNT_WIDTH-1:0] COL_COUNT_RST = 4'd8;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ROW_COUNT = 4'd0,
        CFG_COL_COUNT = 4'd1
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CALC,
        ST_DRAIN,
        ST_OUT_RD,
        ST_OUT_LD
    } gme_state_t;

    // Tag that travels with each operand pair through the MAC
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_tag_t;

    // MAC status toward the sequencer
    typedef struct packed {
        logic done;
        logic busy;
    } mac_stat_t;

    // Start of row r in the packed lower triangle: r*(r+1)/2
    function automatic logic [5:0] tri_base(input logic [IDX_WIDTH-1:0] r);
        logic [5:0] res;
        case (r)
            3'd0:    res = 6'd0;
            3'd1:    res = 6'd1;
            3'd2:    res = 6'd3;
            3'd3:    res = 6'd6;
            3'd4:    res = 6'd10;
            3'd5:    res = 6'd15;
            3'd6:    res = 6'd21;
            3'd7:    res = 6'd28;
            default: res = 6'd0;
        endcase
        return res;
    endfunction

endpackage

// File: sv/gme_mac.sv
// ----------------------------------------------------------------------------
// gme_mac
// Shared multiply-accumulate unit: registered product, then a wrapping
// 38-bit accumulator that restarts on the first beat of each dot product.
// ----------------------------------------------------------------------------
module gme_mac #(
    parameter int ELEM_WIDTH = gme_pkg::ELEM_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gme_pkg::mac_tag_t                 tag,
    input  logic signed [ELEM_WIDTH-1:0]      op_a,
    input  logic signed [ELEM_WIDTH-1:0]      op_b,
    output gme_pkg::mac_stat_t                stat,
    output logic signed [gme_pkg::DOT_WIDTH-1:0] acc
);
    import gme_pkg::*;

    localparam int PW = 2 * ELEM_WIDTH;
    localparam int XW = PW + DOT_WIDTH;

    mac_tag_t                  ptag_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [PW-1:0]      prod_next;
    logic signed [XW-1:0]      prod_x;
    logic signed [DOT_WIDTH-1:0] prod_dw;
    logic signed [DOT_WIDTH-1:0] acc_reg;
    logic signed [DOT_WIDTH-1:0] acc_next;
    logic                      done_reg;

    // product, then sign-extend and wrap to the sum width
    assign prod_next = op_a * op_b;
    assign prod_x    = prod_reg;
    assign prod_dw   = prod_x[DOT_WIDTH-1:0];

    always_comb
    begin
        acc_next = acc_reg;
        if (ptag_reg.valid)
        begin
            acc_next = ptag_reg.first ? prod_dw : acc_reg + prod_dw;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptag_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ptag_reg <= tag;
            done_reg <= ptag_reg.valid & ptag_reg.last;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc       = acc_reg;
    assign stat.done = done_reg;
    assign stat.busy = ptag_reg.valid | done_reg;

endmodule

// File: sv/gram_matrix_engine.sv
// ----------------------------------------------------------------------------
// gram_matrix_engine
// Computes C = A' * A for a column-major matrix A and streams C row-major.
// ----------------------------------------------------------------------------
// The block takes one element of A per cycle while elem_ready is high, on the
// elem channel, column by column, into an on-chip matrix memory. The element
// that completes the matrix starts the computation: one shared multiply-
// accumulate unit walks the lower triangle of C, one product per cycle from
// the two read ports of the matrix memory, and then the MAC pipeline drains.
// The n*n results then leave one at a time through the output register, the
// upper half mirrored from the triangle store. elem_ready is low from the
// completing element until the last result is loaded into the output
// register. Sums are exact, two's complement, wrapping at 38 bits.
// ----------------------------------------------------------------------------
module gram_matrix_engine #(
    parameter int MAX_ROWS   = gme_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = gme_pkg::MAX_COLS_DEF,
    parameter int ELEM_WIDTH = gme_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // element channel
    input  logic                                   elem_valid,
    output logic                                   elem_ready,
    input  logic signed [ELEM_WIDTH-1:0]           element,
    // result channel
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output logic [gme_pkg::IDX_WIDTH-1:0]          result_row,
    output logic [gme_pkg::IDX_WIDTH-1:0]          result_col,
    output logic signed [gme_pkg::DOT_WIDTH-1:0]   dot_value,
    output logic                                   last_entry,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [gme_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [gme_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);
    import gme_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int NW    = $clog2(MAX_COLS + 1);
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int TRI   = (MAX_COLS * (MAX_COLS + 1)) / 2;
    localparam int TAW   = (TRI > 1) ? $clog2(TRI) : 1;

    // configuration registers
    logic [ROW_CNT_WIDTH-1:0] row_count_reg;
    logic [COL_CNT_WIDTH-1:0] col_count_reg;
    logic                     cfg_we;

    // sequencer state and counters
    gme_state_t       st_reg, st_next;
    logic [AW-1:0]    load_cnt_reg, load_cnt_next;
    logic [RW-1:0]    i_reg, i_next;
    logic [CW-1:0]    r_reg, r_next;
    logic [CW-1:0]    c_reg, c_next;
    logic [AW-1:0]    base_r_reg, base_r_next;
    logic [AW-1:0]    base_c_reg, base_c_next;
    logic [TAW-1:0]   tw_reg, tw_next;
    logic [CW-1:0]    orow_reg, orow_next;
    logic [CW-1:0]    ocol_reg, ocol_next;
    mac_tag_t         rd_tag_reg, rd_tag_next;

    // clamped sizes
    logic [RW-1:0]    m_use;
    logic [NW-1:0]    n_use;
    logic [TW-1:0]    total;
    logic [CW-1:0]    n_last;
    logic             load_last;

    // memories
    logic signed [ELEM_WIDTH-1:0] mat_mem [DEPTH];
    logic signed [DOT_WIDTH-1:0]  tri_mem [TRI];
    logic [AW-1:0]                addr_a, addr_b;
    logic signed [ELEM_WIDTH-1:0] rd_a_reg, rd_b_reg;
    logic [TAW-1:0]               tri_raddr;
    logic signed [DOT_WIDTH-1:0]  tri_rd_reg;
    logic                         mem_we;

    // MAC
    mac_stat_t                    mac_stat;
    logic signed [DOT_WIDTH-1:0]  mac_acc;

    // output register
    logic                         out_free;
    logic                         out_load;
    logic                         out_last;
    logic                         res_valid_reg;
    logic [IDX_WIDTH-1:0]         row_out_reg;
    logic [IDX_WIDTH-1:0]         col_out_reg;
    logic signed [DOT_WIDTH-1:0]  dot_out_reg;
    logic                         last_out_reg;

    logic [CW-1:0]                big_idx, small_idx;

    // clamp the configured sizes to their usable range
    always_comb
    begin
        if (row_count_reg == '0)
            m_use = RW'(1);
        else if (row_count_reg > MAX_ROWS)
            m_use = RW'(MAX_ROWS);
        else
            m_use = RW'(row_count_reg);

        if (col_count_reg == '0)
            n_use = NW'(1);
        else if (col_count_reg > MAX_COLS)
            n_use = NW'(MAX_COLS);
        else
            n_use = NW'(col_count_reg);
    end

    assign total     = TW'(m_use) * TW'(n_use);
    assign n_last    = CW'(n_use - NW'(1));
    assign load_last = (TW'(load_cnt_reg) + TW'(1)) == total;

    // operand addresses: column base plus row offset
    assign addr_a = base_r_reg + AW'(i_reg);
    assign addr_b = base_c_reg + AW'(i_reg);

    // mirrored triangle address for the output walk
    assign big_idx   = (ocol_reg <= orow_reg) ? orow_reg : ocol_reg;
    assign small_idx = (ocol_reg <= orow_reg) ? ocol_reg : orow_reg;
    assign tri_raddr = TAW'(tri_base(IDX_WIDTH'(big_idx))) + TAW'(small_idx);

    assign out_free = !res_valid_reg || res_ready;
    assign out_last = (orow_reg == n_last) && (ocol_reg == n_last);

    // configuration write decode
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready &&
                       (cfg_index == CFG_ROW_COUNT || cfg_index == CFG_COL_COUNT);

    // next state and sequencer outputs
    always_comb
    begin
        st_next       = st_reg;
        load_cnt_next = load_cnt_reg;
        i_next        = i_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        base_r_next   = base_r_reg;
        base_c_next   = base_c_reg;
        tw_next       = tw_reg;
        orow_next     = orow_reg;
        ocol_next     = ocol_reg;
        rd_tag_next   = '0;
        elem_ready    = 1'b0;
        mem_we        = 1'b0;
        out_load      = 1'b0;

        case (st_reg)
            ST_LOAD:
            begin
                elem_ready = 1'b1;
                if (elem_valid)
                begin
                    mem_we = 1'b1;
                    if (load_last)
                    begin
                        load_cnt_next = '0;
                        i_next        = '0;
                        r_next        = '0;
                        c_next        = '0;
                        base_r_next   = '0;
                        base_c_next   = '0;
                        tw_next       = '0;
                        st_next       = ST_CALC;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + AW'(1);
                    end
                end
            end

            // one operand pair per cycle over the lower triangle
            ST_CALC:
            begin
                rd_tag_next.valid = 1'b1;
                rd_tag_next.first = (i_reg == '0);
                rd_tag_next.last  = (i_reg == m_use - RW'(1));
                if (i_reg == m_use - RW'(1))
                begin
                    i_next = '0;
                    if (c_reg == r_reg)
                    begin
                        c_next      = '0;
                        base_c_next = '0;
                        if (r_reg == n_last)
                        begin
                            st_next = ST_DRAIN;
                        end
                        else
                        begin
                            r_next      = r_reg + CW'(1);
                            base_r_next = base_r_reg + AW'(m_use);
                        end
                    end
                    else
                    begin
                        c_next      = c_reg + CW'(1);
                        base_c_next = base_c_reg + AW'(m_use);
                    end
                end
                else
                begin
                    i_next = i_reg + RW'(1);
                end
            end

            // wait for the last sum to land in the triangle store
            ST_DRAIN:
            begin
                if (!rd_tag_reg.valid && !mac_stat.busy)
                begin
                    orow_next = '0;
                    ocol_next = '0;
                    st_next   = ST_OUT_RD;
                end
            end

            ST_OUT_RD:
            begin
                if (out_free)
                    st_next = ST_OUT_LD;
            end

            ST_OUT_LD:
            begin
                out_load = 1'b1;
                st_next  = ST_OUT_RD;
                if (ocol_reg == n_last)
                begin
                    ocol_next = '0;
                    if (orow_reg == n_last)
                        st_next = ST_LOAD;
                    else
                        orow_next = orow_reg + CW'(1);
                end
                else
                begin
                    ocol_next = ocol_reg + CW'(1);
                end
            end

            default:
            begin
                st_next = ST_LOAD;
            end
        endcase

        // a finished dot product takes the next triangle slot
        if (mac_stat.done)
            tw_next = tw_reg + TAW'(1);

        // a register write abandons a partial matrix
        if (cfg_we)
            load_cnt_next = '0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_LOAD;
            row_count_reg <= ROW_COUNT_RST;
            col_count_reg <= COL_COUNT_RST;
            load_cnt_reg  <= '0;
            i_reg         <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            base_r_reg    <= '0;
            base_c_reg    <= '0;
            tw_reg        <= '0;
            orow_reg      <= '0;
            ocol_reg      <= '0;
            rd_tag_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg       <= st_next;
            load_cnt_reg <= load_cnt_next;
            i_reg        <= i_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            base_r_reg   <= base_r_next;
            base_c_reg   <= base_c_next;
            tw_reg       <= tw_next;
            orow_reg     <= orow_next;
            ocol_reg     <= ocol_next;
            rd_tag_reg   <= rd_tag_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROW_COUNT: row_count_reg <= cfg_data[ROW_CNT_WIDTH-1:0];
                    CFG_COL_COUNT: col_count_reg <= cfg_data[COL_CNT_WIDTH-1:0];
                    default:       ;
                endcase
            end

            if (out_load)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // matrix memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mat_mem[load_cnt_reg] <= element;
        rd_a_reg <= mat_mem[addr_a];
        rd_b_reg <= mat_mem[addr_b];
    end

    // lower triangle store
    always_ff @(posedge clk)
    begin
        if (mac_stat.done)
            tri_mem[tw_reg] <= mac_acc;
        tri_rd_reg <= tri_mem[tri_raddr];
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            row_out_reg  <= IDX_WIDTH'(orow_reg);
            col_out_reg  <= IDX_WIDTH'(ocol_reg);
            dot_out_reg  <= tri_rd_reg;
            last_out_reg <= out_last;
        end
    end

    gme_mac #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .tag   (rd_tag_reg),
        .op_a  (rd_a_reg),
        .op_b  (rd_b_reg),
        .stat  (mac_stat),
        .acc   (mac_acc)
    );

    assign res_valid  = res_valid_reg;
    assign result_row = row_out_reg;
    assign result_col = col_out_reg;
    assign dot_value  = dot_out_reg;
    assign last_entry = last_out_reg;

endmodule
